/* hw/rtl/hrke_pkg.sv */
// Shared types and constants for the HID report to key event unit.
package hrke_pkg;

    typedef struct packed {
        logic       mode;
        logic       attach;
        logic [7:0] report_byte0;
        logic [7:0] report_byte1;
        logic [7:0] report_byte2;
        logic [7:0] report_byte3;
        logic [7:0] report_byte4;
        logic [7:0] report_byte5;
        logic [7:0] report_byte6;
        logic [7:0] report_byte7;
        logic [3:0] report_length;
    } in_t;

    typedef struct packed {
        logic        target;
        logic        override;
        logic        go;
        logic        make;
        logic [7:0]  key_code;
        logic [11:0] joystick_pins;
        logic        last;
    } out_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_ATTACH,
        SEL_CHORD,
        SEL_MOD,
        SEL_SLOT,
        SEL_JOY
    } sel_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       flush;
        logic       store;
        logic       set_override;
        logic       set_joy;
        sel_t       sel;
        logic [2:0] idx;
        logic       phase;
    } dp_cmd_t;

    typedef struct packed {
        logic       is_attach;
        logic       is_chord;
        logic       joy_mode;
        logic       override_on;
        logic [3:0] len;
        logic       stall;
        logic       out_free;
        logic       pend_valid;
    } dp_stat_t;

    localparam logic [2:0] LAST_IDX       = 3'd7;
    localparam logic [2:0] CHORD_LAST_IDX = 3'd2;

    localparam logic [7:0] CHORD_MODS     = 8'h05;
    localparam logic [7:0] KEY_K          = 8'h0E;
    localparam logic [7:0] KEY_J          = 8'h0D;
    localparam logic [7:0] MOD_KEY_BASE   = 8'h78;
    localparam logic [7:0] CHORD_BREAK0   = 8'h79;
    localparam logic [7:0] CHORD_BREAK1   = 8'h7C;

    localparam logic [7:0] KEY_UP         = 8'h52;
    localparam logic [7:0] KEY_DOWN       = 8'h51;
    localparam logic [7:0] KEY_LEFT       = 8'h50;
    localparam logic [7:0] KEY_RIGHT      = 8'h4F;
    localparam logic [7:0] KEY_Z          = 8'h1D;
    localparam logic [7:0] KEY_X          = 8'h1B;
    localparam logic [7:0] KEY_C          = 8'h06;
    localparam logic [7:0] KEY_5          = 8'h22;
    localparam logic [7:0] KEY_1          = 8'h1E;
    localparam logic [7:0] KEY_F2         = 8'h3B;

    function automatic logic [11:0] pin_of_key(input logic [7:0] code);
        logic [11:0] pins;
        begin
            case (code)
                KEY_UP:    pins = 12'h001;
                KEY_LEFT:  pins = 12'h002;
                KEY_RIGHT: pins = 12'h004;
                KEY_DOWN:  pins = 12'h008;
                KEY_Z:     pins = 12'h040;
                KEY_X:     pins = 12'h080;
                KEY_C:     pins = 12'h100;
                KEY_5:     pins = 12'h200;
                KEY_1:     pins = 12'h400;
                KEY_F2:    pins = 12'h800;
                default:   pins = 12'h000;
            endcase
            return pins;
        end
    endfunction

endpackage

/* hw/rtl/hrke_datapath.sv */
// Datapath: report register, previous report, mode flags, result candidate and output stages.
module hrke_datapath import hrke_pkg::*; #(
    parameter int REPORT_BYTES = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  in_t      in_data,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output logic     out_valid,
    input  logic     out_ready,
    output out_t     out_data
);

    localparam logic [3:0] LEN_MAX = 4'(REPORT_BYTES);

    in_t        cur_reg;
    logic [7:0] prev_reg [REPORT_BYTES];
    logic       joy_reg;
    logic       ovr_reg;
    logic       pend_valid_reg;
    out_t       pend_reg;
    logic       m_valid_reg;
    out_t       m_data_reg;

    logic [7:0]  cur_bytes [8];
    logic [3:0]  len;
    logic [7:0]  prev_sel;
    logic [7:0]  cur_sel;
    logic [11:0] joy_bits;
    logic        cand_valid;
    out_t        cand;
    logic        out_free;
    logic        stall;

    always_comb begin
        cur_bytes[0] = cur_reg.report_byte0;
        cur_bytes[1] = cur_reg.report_byte1;
        cur_bytes[2] = cur_reg.report_byte2;
        cur_bytes[3] = cur_reg.report_byte3;
        cur_bytes[4] = cur_reg.report_byte4;
        cur_bytes[5] = cur_reg.report_byte5;
        cur_bytes[6] = cur_reg.report_byte6;
        cur_bytes[7] = cur_reg.report_byte7;
    end

    assign len     = (cur_reg.report_length > LEN_MAX) ? LEN_MAX : cur_reg.report_length;
    assign cur_sel = cur_bytes[cmd.idx];

    always_comb begin
        prev_sel = '0;
        for (int j = 0; j < REPORT_BYTES; j++) begin
            if (cmd.idx == 3'(j)) begin
                prev_sel = prev_reg[j];
            end
        end
    end

    // Joystick pins: fire and modifier on byte 0, fixed keys on the slots below the length
    always_comb begin
        joy_bits = '0;
        if (len != 4'd0) begin
            joy_bits[4] = cur_reg.report_byte0[0];
            joy_bits[5] = cur_reg.report_byte0[2];
        end
        for (int j = 1; j < 8; j++) begin
            if (4'(j) < len) begin
                joy_bits = joy_bits | pin_of_key(cur_bytes[j]);
            end
        end
    end

    always_comb begin
        cand_valid = 1'b0;
        cand       = '0;
        case (cmd.sel)
            SEL_ATTACH: begin
                cand_valid    = 1'b1;
                cand.override = cur_reg.attach;
            end
            SEL_CHORD: begin
                cand_valid    = 1'b1;
                cand.override = ovr_reg;
                cand.go       = 1'b1;
                if (cmd.idx == 3'd0) begin
                    cand.key_code = CHORD_BREAK0;
                end else if (cmd.idx == 3'd1) begin
                    cand.key_code = CHORD_BREAK1;
                end else begin
                    cand.key_code = cur_reg.report_byte2;
                end
            end
            SEL_MOD: begin
                cand.override = ovr_reg;
                cand.go       = 1'b1;
                cand.make     = cmd.phase;
                cand.key_code = MOD_KEY_BASE | {5'd0, cmd.idx};
                if (cmd.phase) begin
                    cand_valid = cur_reg.report_byte0[cmd.idx];
                end else begin
                    cand_valid = prev_reg[0][cmd.idx] & ~cur_reg.report_byte0[cmd.idx];
                end
            end
            SEL_SLOT: begin
                cand.override = ovr_reg;
                cand.go       = 1'b1;
                cand.make     = cmd.phase;
                if (cmd.phase) begin
                    cand_valid    = (cur_sel != 8'd0);
                    cand.key_code = cur_sel;
                end else begin
                    cand_valid    = (prev_sel != 8'd0) && (cur_sel != prev_sel);
                    cand.key_code = prev_sel;
                end
            end
            SEL_JOY: begin
                cand_valid         = 1'b1;
                cand.target        = 1'b1;
                cand.go            = 1'b1;
                cand.joystick_pins = ~joy_bits;
            end
            default: begin
                cand_valid = 1'b0;
            end
        endcase
    end

    assign out_free = !m_valid_reg || out_ready;
    assign stall    = cmd.step && cand_valid && pend_valid_reg && !out_free;

    always_comb begin
        stat.is_attach   = cur_reg.mode;
        stat.is_chord    = (cur_reg.report_byte0 == CHORD_MODS) &&
                           ((cur_reg.report_byte2 == KEY_K) || (cur_reg.report_byte2 == KEY_J));
        stat.joy_mode    = joy_reg;
        stat.override_on = ovr_reg;
        stat.len         = len;
        stat.stall       = stall;
        stat.out_free    = out_free;
        stat.pend_valid  = pend_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            joy_reg <= 1'b0;
            ovr_reg <= 1'b0;
            for (int j = 0; j < REPORT_BYTES; j++) begin
                prev_reg[j] <= '0;
            end
        end else begin
            if (cmd.set_override) begin
                ovr_reg <= cur_reg.attach;
            end
            if (cmd.set_joy) begin
                joy_reg <= (cur_reg.report_byte2 == KEY_J);
            end
            if (cmd.store) begin
                for (int j = 0; j < REPORT_BYTES; j++) begin
                    if (4'(j) < len) begin
                        prev_reg[j] <= cur_bytes[j];
                    end
                end
            end
        end
    end

    // Hold one result back so the final one can carry last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.step && cand_valid && !stall) begin
                pend_valid_reg <= 1'b1;
                m_valid_reg    <= pend_valid_reg || (m_valid_reg && !out_ready);
            end else if (cmd.flush && pend_valid_reg && out_free) begin
                pend_valid_reg <= 1'b0;
                m_valid_reg    <= 1'b1;
            end else if (m_valid_reg && out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && cand_valid && !stall) begin
            pend_reg <= cand;
            if (pend_valid_reg) begin
                m_data_reg <= {pend_reg[$bits(out_t)-1:1], 1'b0};
            end
        end else if (cmd.flush && pend_valid_reg && out_free) begin
            m_data_reg <= {pend_reg[$bits(out_t)-1:1], 1'b1};
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

endmodule

/* hw/rtl/hrke_ctrl.sv */
// Controller: sequences attach, chord, keyboard compare and joystick steps.
module hrke_ctrl import hrke_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ATTACH,
        ST_CHORD,
        ST_MOD,
        ST_SLOT,
        ST_STORE,
        ST_JOY,
        ST_FLUSH
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.sel    = SEL_NONE;
        cmd.idx    = idx_reg;
        cmd.phase  = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                idx_next   = '0;
                phase_next = 1'b0;
                if (stat.is_attach) begin
                    state_next = ST_ATTACH;
                end else if (stat.is_chord) begin
                    state_next = ST_CHORD;
                end else if (stat.joy_mode) begin
                    state_next = ST_JOY;
                end else if (stat.override_on) begin
                    state_next = ST_MOD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ATTACH: begin
                cmd.step = 1'b1;
                cmd.sel  = SEL_ATTACH;
                if (!stat.stall) begin
                    cmd.set_override = 1'b1;
                    state_next       = ST_FLUSH;
                end
            end
            ST_CHORD: begin
                cmd.step = 1'b1;
                cmd.sel  = SEL_CHORD;
                if (!stat.stall) begin
                    if (idx_reg == CHORD_LAST_IDX) begin
                        cmd.set_joy = 1'b1;
                        state_next  = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_MOD: begin
                cmd.step = 1'b1;
                cmd.sel  = SEL_MOD;
                if (!stat.stall) begin
                    if (!phase_reg) begin
                        phase_next = 1'b1;
                    end else begin
                        phase_next = 1'b0;
                        if (idx_reg == LAST_IDX) begin
                            idx_next   = 3'd1;
                            state_next = ST_SLOT;
                        end else begin
                            idx_next = idx_reg + 3'd1;
                        end
                    end
                end
            end
            ST_SLOT: begin
                if ({1'b0, idx_reg} >= stat.len) begin
                    state_next = ST_STORE;
                end else begin
                    cmd.step = 1'b1;
                    cmd.sel  = SEL_SLOT;
                    if (!stat.stall) begin
                        if (!phase_reg) begin
                            phase_next = 1'b1;
                        end else begin
                            phase_next = 1'b0;
                            if (idx_reg == LAST_IDX) begin
                                state_next = ST_STORE;
                            end else begin
                                idx_next = idx_reg + 3'd1;
                            end
                        end
                    end
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_FLUSH;
            end
            ST_JOY: begin
                cmd.step = 1'b1;
                cmd.sel  = SEL_JOY;
                if (!stat.stall) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cmd.flush = 1'b1;
                if (!stat.pend_valid || stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/hid_report_to_key_events_unit.sv */
// Top level of the HID report to key event unit: controller, datapath and checks.
//
// Takes one USB boot-keyboard report or one attach/detach event per input transfer and
// produces the port writes it causes as result transfers, the final one flagged by last.
// An attach event gives one write and updates the override flag. The Ctrl+Alt+K and
// Ctrl+Alt+J chords give three break writes and pick keyboard or joystick mode. In keyboard
// mode, while attached, each modifier bit and each key slot below the report length is
// checked against the stored previous report: a break for what was released or changed,
// then a make for what is held; the report is then stored. In joystick mode one pin write
// with 12 active-low pins is sent. Reports in keyboard mode while detached give nothing.
// One item is processed at a time; a single result sequencer walks the candidates, one
// per cycle unless the result side holds off. After accept and decode, a keyboard report
// takes a break step and a make step for each modifier bit and each key slot below the
// length, then store and flush. One result is kept back internally so the last flag is
// known; the output register lets the next input transfer be accepted while the final
// result of the previous item still waits.
module hid_report_to_key_events_unit import hrke_pkg::*; #(
    parameter int REPORT_BYTES = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence the steps of each item
    hrke_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold report, previous report and mode flags; build and stage results
    hrke_datapath #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // No held-back result may remain once the unit is ready for a new item
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !stat.pend_valid)
        else $error("held-back result left over while idle");

    // A joystick pin write is always the only, hence last, result of its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.target) |-> m_data.last)
        else $error("pin write not flagged last");

    // A write without strobe comes only from an attach event: keyboard port, single result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.go) |-> (m_data.last && !m_data.target && !m_data.make))
        else $error("unstrobed write is not a lone attach result");

endmodule

/* test/hid_report_to_key_events_unit_test.sv */
`timescale 1ns / 1ps
// Testbench for hid_report_to_key_events_unit: predicts each port write and checks every transfer.
module hid_report_to_key_events_unit_test;
    import hrke_pkg::*;

    localparam int CLK_HIGH_NS    = 10;
    localparam int CLK_LOW_NS     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int TARGET_ITEMS   = 310;
    localparam int DRAIN_EVERY    = 100;
    // Extra run time after the last expected write, so that any unexpected write still shows up.
    localparam int TAIL_CYCLES    = 120;
    // No transfer on either side for this long means the block is stuck.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED    = 40;

    // Modifier bits that land on joystick pins.
    localparam logic [7:0] MOD_CTRL = 8'h01;
    localparam logic [7:0] MOD_ALT  = 8'h04;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_WINDOW,
        RX_STARVED
    } rx_style_t;

    // Scoreboard: mirrors the block state and holds the writes still to come, oldest first.
    class key_event_scoreboard;
        logic [7:0] held_report [8] = '{default: 8'h00};
        bit         joystick_on;
        bit         kbd_attached;
        out_t       pending_writes [$];
        int         mismatches;
        int         printed;

        function void push_write(bit target, bit ovr, bit go, bit mk, logic [7:0] code,
                                 logic [11:0] pins);
            out_t w;
            w.target        = target;
            w.override      = ovr;
            w.go            = go;
            w.make          = mk;
            w.key_code      = code;
            w.joystick_pins = pins;
            w.last          = 1'b0;
            pending_writes.push_back(w);
        endfunction

        // Work out the writes caused by one accepted input; return how many.
        function int note_input(in_t item);
            logic [7:0]  cur [8];
            logic [11:0] pins_on;
            out_t        tail_write;
            int          len;
            int          first;
            first   = pending_writes.size();
            pins_on = 12'h000;
            cur[0]  = item.report_byte0;
            cur[1]  = item.report_byte1;
            cur[2]  = item.report_byte2;
            cur[3]  = item.report_byte3;
            cur[4]  = item.report_byte4;
            cur[5]  = item.report_byte5;
            cur[6]  = item.report_byte6;
            cur[7]  = item.report_byte7;
            len     = (item.report_length > 4'd8) ? 8 : int'(item.report_length);

            if (item.mode) begin
                kbd_attached = item.attach;
                push_write(1'b0, kbd_attached, 1'b0, 1'b0, 8'h00, 12'h000);
            end else if (cur[0] == CHORD_MODS && (cur[2] == KEY_K || cur[2] == KEY_J)) begin
                // Chord: release Ctrl, Alt and the letter, whether attached or not.
                push_write(1'b0, kbd_attached, 1'b1, 1'b0, CHORD_BREAK0, 12'h000);
                push_write(1'b0, kbd_attached, 1'b1, 1'b0, CHORD_BREAK1, 12'h000);
                push_write(1'b0, kbd_attached, 1'b1, 1'b0, cur[2], 12'h000);
                joystick_on = (cur[2] == KEY_J);
            end else if (!joystick_on) begin
                if (kbd_attached) begin
                    for (int i = 0; i < 8; i++) begin
                        if (held_report[0][i] && !cur[0][i])
                            push_write(1'b0, 1'b1, 1'b1, 1'b0, MOD_KEY_BASE | i[7:0], 12'h000);
                        if (cur[0][i])
                            push_write(1'b0, 1'b1, 1'b1, 1'b1, MOD_KEY_BASE | i[7:0], 12'h000);
                    end
                    for (int i = 1; i < len; i++) begin
                        if (held_report[i] != 8'h00 && cur[i] != held_report[i])
                            push_write(1'b0, 1'b1, 1'b1, 1'b0, held_report[i], 12'h000);
                        if (cur[i] != 8'h00)
                            push_write(1'b0, 1'b1, 1'b1, 1'b1, cur[i], 12'h000);
                    end
                    for (int i = 0; i < len; i++)
                        held_report[i] = cur[i];
                end
            end else begin
                for (int i = 0; i < len; i++) begin
                    if (i == 0) begin
                        if ((cur[0] & MOD_CTRL) != 8'h00) pins_on[4] = 1'b1;
                        if ((cur[0] & MOD_ALT) != 8'h00) pins_on[5] = 1'b1;
                    end else begin
                        case (cur[i])
                            KEY_UP:    pins_on[0]  = 1'b1;
                            KEY_LEFT:  pins_on[1]  = 1'b1;
                            KEY_RIGHT: pins_on[2]  = 1'b1;
                            KEY_DOWN:  pins_on[3]  = 1'b1;
                            KEY_Z:     pins_on[6]  = 1'b1;
                            KEY_X:     pins_on[7]  = 1'b1;
                            KEY_C:     pins_on[8]  = 1'b1;
                            KEY_5:     pins_on[9]  = 1'b1;
                            KEY_1:     pins_on[10] = 1'b1;
                            KEY_F2:    pins_on[11] = 1'b1;
                            default: ;
                        endcase
                    end
                end
                push_write(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, ~pins_on);
            end

            // Flag the final write of this input.
            if (pending_writes.size() > first) begin
                tail_write      = pending_writes.pop_back();
                tail_write.last = 1'b1;
                pending_writes.push_back(tail_write);
            end
            return pending_writes.size() - first;
        endfunction

        task report_mismatch(string what, logic [11:0] got_v, logic [11:0] want_v);
            mismatches++;
            if (printed < MAX_PRINTED) begin
                printed++;
                $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                         $time, what, got_v, want_v);
            end
        endtask

        task check_result(out_t got);
            out_t want;
            if (pending_writes.size() == 0) begin
                report_mismatch("write with nothing expected", 12'(got.key_code), 12'h000);
            end else begin
                want = pending_writes.pop_front();
                if (got.target !== want.target)
                    report_mismatch("target", 12'(got.target), 12'(want.target));
                if (got.override !== want.override)
                    report_mismatch("override", 12'(got.override), 12'(want.override));
                if (got.go !== want.go)
                    report_mismatch("go", 12'(got.go), 12'(want.go));
                if (got.make !== want.make)
                    report_mismatch("make", 12'(got.make), 12'(want.make));
                if (got.key_code !== want.key_code)
                    report_mismatch("key_code", 12'(got.key_code), 12'(want.key_code));
                if (got.joystick_pins !== want.joystick_pins)
                    report_mismatch("joystick_pins", got.joystick_pins, want.joystick_pins);
                if (got.last !== want.last)
                    report_mismatch("last", 12'(got.last), 12'(want.last));
            end
        endtask
    endclass

    // All block inputs start at known values.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    key_event_scoreboard sb;
    int                  items_counted;
    int                  burst_left;
    int                  idle_cycles;
    logic [15:0]         rx_count;
    rx_style_t           rx_style;

    hid_report_to_key_events_unit #(
        .REPORT_BYTES(8)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #CLK_LOW_NS aclk = 1'b1;
        #CLK_HIGH_NS aclk = 1'b0;
    end

    // Every field random; callers then overwrite what matters.
    function automatic in_t noise_item();
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        return noise[$bits(in_t)-1:0];
    endfunction

    function automatic in_t kbd_report(logic [7:0] mods, logic [55:0] slots, logic [3:0] len);
        in_t item;
        item = '0;
        item.report_byte0  = mods;
        {item.report_byte1, item.report_byte2, item.report_byte3, item.report_byte4,
         item.report_byte5, item.report_byte6, item.report_byte7} = slots;
        item.report_length = len;
        return item;
    endfunction

    function automatic in_t attach_event(logic attached);
        in_t item;
        item        = noise_item();
        item.mode   = 1'b1;
        item.attach = attached;
        return item;
    endfunction

    // Plausible report: held keys carry over, mapped joystick keys show up often.
    function automatic in_t random_report();
        in_t        item;
        logic [7:0] slot [8];
        int         r;
        item = noise_item();
        item.mode = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 40)
            slot[0] = 8'($urandom_range(0, 255));
        else if (r < 70)
            slot[0] = sb.held_report[0];
        else
            slot[0] = 8'h01 << $urandom_range(0, 7);
        for (int i = 1; i < 8; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                slot[i] = 8'h00;
            end else if (r < 50) begin
                case ($urandom_range(0, 9))
                    0: slot[i] = KEY_UP;
                    1: slot[i] = KEY_DOWN;
                    2: slot[i] = KEY_LEFT;
                    3: slot[i] = KEY_RIGHT;
                    4: slot[i] = KEY_Z;
                    5: slot[i] = KEY_X;
                    6: slot[i] = KEY_C;
                    7: slot[i] = KEY_5;
                    8: slot[i] = KEY_1;
                    default: slot[i] = KEY_F2;
                endcase
            end else if (r < 70) begin
                slot[i] = sb.held_report[i];
            end else begin
                slot[i] = 8'($urandom_range(1, 255));
            end
        end
        item.report_byte0  = slot[0];
        item.report_byte1  = slot[1];
        item.report_byte2  = slot[2];
        item.report_byte3  = slot[3];
        item.report_byte4  = slot[4];
        item.report_byte5  = slot[5];
        item.report_byte6  = slot[6];
        item.report_byte7  = slot[7];
        item.report_length = ($urandom_range(0, 3) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
        return item;
    endfunction

    task automatic wait_drained();
        @(posedge aclk);
        while (sb.pending_writes.size() != 0) @(posedge aclk);
    endtask

    // Present one item, hold it until the transfer, then pace the next one.
    task automatic send_item(input in_t item, input bit drain_after);
        int gap;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        void'(sb.note_input(item));
        items_counted++;
        if (items_counted % DRAIN_EVERY == 0) drain_after = 1'b1;
        burst_left--;
        if (burst_left <= 0 || drain_after) begin
            s_valid <= 1'b0;
            // Hold off until every write so far has come out.
            if (drain_after) wait_drained();
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Receiver: check each accepted write, then pick ready from the current stall pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_count <= '0;
            rx_style <= RX_OPEN;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_data);
            rx_count <= rx_count + 16'd1;
            if (rx_count[7:0] == 8'hFF) rx_style <= rx_style_t'($urandom_range(0, 3));
            case (rx_style)
                RX_OPEN:    m_ready <= 1'b1;
                RX_RANDOM:  m_ready <= ($urandom_range(0, 3) != 0);
                RX_WINDOW:  m_ready <= (rx_count[3:0] < 4'd4);
                RX_STARVED: m_ready <= ($urandom_range(0, 9) == 0);
                default:    m_ready <= 1'b1;
            endcase
        end
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        in_t directed [$];
        in_t item;
        int  r;
        sb            = new();
        items_counted = 0;
        burst_left    = 4;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Detached keyboard mode: report is dropped, chord still releases its keys.
        directed.push_back(kbd_report(8'h02, {8'h04, 48'h0}, 4'd8));
        directed.push_back(kbd_report(CHORD_MODS, {8'h00, KEY_K, 40'h0}, 4'd8));
        directed.push_back(attach_event(1'b1));
        // Extremes of the report bytes, then release of everything.
        directed.push_back(kbd_report(8'h00, 56'h0, 4'd8));
        directed.push_back(kbd_report(8'hFF, 56'hFFFF_FFFF_FFFF_FF, 4'd8));
        directed.push_back(kbd_report(8'h00, 56'h0405_0607_0809_0A, 4'd8));
        // Unchanged report repeats every make.
        directed.push_back(kbd_report(8'h00, 56'h0405_0607_0809_0A, 4'd8));
        // Zero length stores nothing; oversize length saturates; short reports.
        directed.push_back(kbd_report(8'h81, 56'h1112_1314_1516_17, 4'd0));
        directed.push_back(kbd_report(8'h00, 56'h0, 4'd15));
        directed.push_back(kbd_report(8'h10, 56'h2C2D_3333_3333_33, 4'd3));
        directed.push_back(kbd_report(8'h00, {8'h99, 48'h0}, 4'd1));
        // Near misses of the chord.
        directed.push_back(kbd_report(8'h04, {8'h00, KEY_K, 40'h0}, 4'd8));
        directed.push_back(kbd_report(CHORD_MODS, {8'h00, 8'h0F, 40'h0}, 4'd8));
        // Joystick chord with a short length still checks byte 2.
        directed.push_back(kbd_report(CHORD_MODS, {8'h00, KEY_J, 40'h0}, 4'd2));
        directed.push_back(kbd_report(MOD_CTRL,
                                      {KEY_UP, KEY_LEFT, KEY_RIGHT, KEY_DOWN, KEY_Z, KEY_X, KEY_C},
                                      4'd8));
        directed.push_back(kbd_report(MOD_ALT, {KEY_5, KEY_1, KEY_F2, 32'h0}, 4'd4));
        directed.push_back(kbd_report(8'hFF, {7{KEY_UP}}, 4'd1));
        directed.push_back(kbd_report(8'hFF, {7{KEY_UP}}, 4'd0));
        directed.push_back(kbd_report(8'hFF, 56'hFFFF_FFFF_FFFF_FF, 4'd8));
        directed.push_back(attach_event(1'b0));
        directed.push_back(kbd_report(CHORD_MODS, {8'h00, KEY_K, 40'h0}, 4'd8));
        directed.push_back(kbd_report(8'h20, {8'h1A, 48'h0}, 4'd8));
        directed.push_back(attach_event(1'b1));
        directed.push_back(kbd_report(CHORD_MODS, {KEY_K, 48'h0}, 4'd8));

        foreach (directed[k]) send_item(directed[k], k == directed.size() - 1);

        while (items_counted < TARGET_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 7 || (!sb.kbd_attached && !sb.joystick_on && r < 40)) begin
                item = attach_event($urandom_range(0, 4) != 0);
            end else if (r < 14) begin
                item = noise_item();
                item.mode         = 1'b0;
                item.report_byte0 = CHORD_MODS;
                item.report_byte2 = ($urandom_range(0, 2) == 0) ? KEY_J : KEY_K;
            end else if (r < 18) begin
                // Broken chord: one bit off in the modifiers or in the letter.
                item = random_report();
                if ($urandom_range(0, 1) == 0) begin
                    item.report_byte0 = CHORD_MODS ^ (8'h01 << $urandom_range(0, 7));
                    item.report_byte2 = KEY_K;
                end else begin
                    item.report_byte0 = CHORD_MODS;
                    item.report_byte2 = KEY_K ^ (8'h01 << $urandom_range(0, 7));
                end
            end else begin
                item = random_report();
            end
            send_item(item, 1'b0);
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/hrke_pkg.sv
hw/rtl/hrke_datapath.sv
hw/rtl/hrke_ctrl.sv
hw/rtl/hid_report_to_key_events_unit.sv
test/hid_report_to_key_events_unit_test.sv
